@@ rtl/the_pkg.sv @@
`default_nettype none
// ============================================================================
// Tilt/heading package
// Shared constants and the queue entry type of the tilt and heading estimator.
// ============================================================================
package the_pkg;
    localparam int AngleFracBits   = 7;
    localparam int HeadingFracBits = 24;
    localparam int CordicSteps     = 20;
    localparam int IntAngBits      = 16;
    localparam int HdgW            = 33;
    localparam int RateMin         = 4;
    localparam int RateMax         = 6400;
    localparam int CW              = 50;  // CORDIC datapath width
    localparam int ZW              = 26;  // angle accumulator width
    localparam logic [HdgW-1:0] FullTurn = HdgW'(64'd360 << HeadingFracBits);
    localparam logic [31:0] GyroScale =
        32'(((64'd305 << HeadingFracBits) + 64'd5000) / 64'd10000);

    typedef struct packed {
        logic               kind;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } item_t;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        unique case (i)
            5'd0:  v = 26'sd2949120;
            5'd1:  v = 26'sd1740967;
            5'd2:  v = 26'sd919879;
            5'd3:  v = 26'sd466945;
            5'd4:  v = 26'sd234379;
            5'd5:  v = 26'sd117304;
            5'd6:  v = 26'sd58666;
            5'd7:  v = 26'sd29335;
            5'd8:  v = 26'sd14668;
            5'd9:  v = 26'sd7334;
            5'd10: v = 26'sd3667;
            5'd11: v = 26'sd1833;
            5'd12: v = 26'sd917;
            5'd13: v = 26'sd458;
            5'd14: v = 26'sd229;
            5'd15: v = 26'sd115;
            5'd16: v = 26'sd57;
            5'd17: v = 26'sd29;
            5'd18: v = 26'sd14;
            5'd19: v = 26'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

@@ rtl/the_queue.sv @@
`default_nettype none
// ============================================================================
// Item queue
// Two-entry queue between the front end and the compute engine.
// ============================================================================
module the_queue
    import the_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  item_t      din,
    output logic       full,
    input  wire logic  pop,
    output item_t      dout,
    output logic       empty
);
    item_t       mem [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign dout  = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem[wp_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop && !empty)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
        end
    end
endmodule
`default_nettype wire

@@ rtl/the_engine.sv @@
`default_nettype none
// ============================================================================
// Compute engine
// Sequencer with a shared CORDIC, a bit-serial square root and a restoring
// divider for the heading increment; one result register at the output.
// ============================================================================
module the_engine
    import the_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [12:0]        rate,
    input  item_t                   item,
    input  wire logic               item_valid,
    output logic                    item_take,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [15:0]      roll,
    output logic signed [14:0]      pitch,
    output logic [15:0]             heading,
    output logic signed [15:0]      out_accel_x,
    output logic signed [15:0]      out_accel_y,
    output logic signed [15:0]      out_accel_z,
    output logic signed [15:0]      out_gyro_x,
    output logic signed [15:0]      out_gyro_y,
    output logic signed [15:0]      out_gyro_z
);
    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ROLL_INIT, S_ROLL, S_SQRT, S_PITCH_INIT, S_PITCH,
        S_DIV, S_HDG, S_OUT
    } state_t;

    state_t                 state_reg;
    item_t                  it_reg;
    logic [HdgW-1:0]        hdg_reg;
    logic signed [15:0]     prev_reg;
    logic signed [CW-1:0]   x_reg, y_reg;
    logic signed [ZW-1:0]   z_reg;
    logic [4:0]             step_reg;
    logic                   skip_reg;
    logic signed [15:0]     roll_reg;
    logic [52:0]            sq_n_reg;
    logic [52:0]            sq_res_reg;
    logic [52:0]            sq_bit_reg;
    logic [49:0]            num_reg;    // magnitude of numerator
    logic                   neg_reg;
    logic [13:0]            den_reg;
    logic [49:0]            quo_reg;
    logic [14:0]            rem_reg;
    logic [5:0]             dcnt_reg;
    logic                   full_reg;
    logic signed [15:0]     o_roll_reg;
    logic signed [14:0]     o_pitch_reg;
    logic [15:0]            o_hdg_reg;
    item_t                  o_it_reg;

    logic [12:0] rate_c;
    always_comb
    begin
        rate_c = rate;
        if (rate < 13'(RateMin)) rate_c = 13'(RateMin);
        if (rate > 13'(RateMax)) rate_c = 13'(RateMax);
    end

    // One CORDIC iteration.
    logic signed [CW-1:0] dx, dy, xn, yn;
    logic signed [ZW-1:0] zn;
    always_comb
    begin
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        if (y_reg > 0)
        begin
            xn = x_reg + dx; yn = y_reg - dy; zn = z_reg + atan_entry(step_reg);
        end
        else
        begin
            xn = x_reg - dx; yn = y_reg + dy; zn = z_reg - atan_entry(step_reg);
        end
    end

    // Rounding to the output unit and clamping.
    function automatic logic signed [15:0] out_ang(input logic signed [ZW-1:0] z,
                                                   input logic signed [15:0] lim);
        logic signed [ZW-1:0] r;
        r = (z + ZW'(1 <<< (IntAngBits - AngleFracBits - 1)))
            >>> (IntAngBits - AngleFracBits);
        if (r > ZW'(lim)) r = ZW'(lim);
        if (r < -ZW'(lim)) r = -ZW'(lim);
        return 16'(r);
    endfunction

    localparam logic signed [ZW-1:0] Deg180 = ZW'(180 <<< IntAngBits);
    localparam logic signed [ZW-1:0] Deg90  = ZW'(90 <<< IntAngBits);
    localparam logic signed [15:0] Lim180 = 16'(180 <<< AngleFracBits);
    localparam logic signed [15:0] Lim90  = 16'(90 <<< AngleFracBits);

    // Special-case handling and quadrant fold at CORDIC entry.
    logic                  ini_skip;
    logic signed [ZW-1:0]  ini_z;
    logic signed [CW-1:0]  ini_x, ini_y;
    logic signed [CW-1:0]  op_y, op_x;
    always_comb
    begin
        ini_skip = 1'b0; ini_z = '0;
        if (op_y == 0)
        begin
            ini_skip = 1'b1; ini_z = (op_x >= 0) ? '0 : Deg180;
        end
        else if (op_x == 0)
        begin
            ini_skip = 1'b1; ini_z = (op_y > 0) ? Deg90 : -Deg90;
        end
        else if (op_x < 0)
        begin
            ini_z = (op_y > 0) ? Deg180 : -Deg180;
        end
        ini_x = ((op_x < 0) ? -op_x : op_x) <<< 20;
        ini_y = ((op_x < 0) ? -op_y : op_y) <<< 20;
    end
    always_comb
    begin
        if (state_reg == S_ROLL_INIT)
        begin
            op_y = CW'(it_reg.accel_y); op_x = CW'(it_reg.accel_z);
        end
        else
        begin
            op_y = -(CW'(it_reg.accel_x) <<< 10); op_x = CW'(sq_res_reg);
        end
    end

    logic [52:0] sq_try;
    assign sq_try = sq_res_reg + sq_bit_reg;
    logic [14:0] rem_sh;
    assign rem_sh = {rem_reg[13:0], num_reg[49]};

    logic out_load;
    assign out_load = (state_reg == S_OUT) && (!full_reg || pop);

    assign item_take = (state_reg == S_IDLE) && item_valid && (item.kind || !full_reg);
    assign empty = !full_reg;

    logic signed [16:0] gsum;
    assign gsum = 17'(it_reg.gyro_z) + 17'(prev_reg);
    // Magnitude as an unsigned value, so that the most negative sum stays exact.
    logic [16:0] gmag;
    assign gmag = gsum[16] ? 17'(-gsum) : 17'(gsum);

    logic signed [32:0] sq_prod;
    always_comb
    begin
        sq_prod = (step_reg == 5'd0) ? it_reg.accel_y * it_reg.accel_y
                                     : it_reg.accel_z * it_reg.accel_z;
    end

    logic [HdgW:0] hdg_up;
    assign hdg_up = (HdgW+1)'(hdg_reg) + (HdgW+1)'(quo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hdg_reg   <= '0;
            prev_reg  <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
                full_reg <= 1'b1;
            else if (pop && full_reg)
                full_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_take)
                    begin
                        it_reg <= item;
                        if (item.kind)
                        begin
                            hdg_reg <= '0; prev_reg <= '0;
                        end
                        else
                        begin
                            state_reg <= S_MUL;
                            sq_n_reg <= '0;
                            step_reg <= '0;
                        end
                    end
                end
                S_MUL:
                begin
                    // Accumulate ay^2 then az^2, one multiply per cycle.
                    sq_n_reg <= sq_n_reg + (53'(sq_prod) << 20);
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd1) state_reg <= S_ROLL_INIT;
                end
                S_ROLL_INIT:
                begin
                    x_reg <= ini_x; y_reg <= ini_y; z_reg <= ini_z;
                    skip_reg <= ini_skip; step_reg <= '0;
                    state_reg <= S_ROLL;
                    sq_res_reg <= '0;
                    sq_bit_reg <= 53'(1) << 52;
                end
                S_ROLL:
                begin
                    if (!skip_reg)
                    begin
                        x_reg <= xn; y_reg <= yn; z_reg <= zn;
                    end
                    step_reg <= step_reg + 5'd1;
                    if (skip_reg || step_reg == 5'(CordicSteps - 1))
                    begin
                        roll_reg  <= out_ang(skip_reg ? z_reg : zn, Lim180);
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    // One result bit per cycle.
                    if (sq_n_reg >= sq_try)
                    begin
                        sq_n_reg   <= sq_n_reg - sq_try;
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end
                    else
                    begin
                        sq_res_reg <= sq_res_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg[0]) state_reg <= S_PITCH_INIT;
                end
                S_PITCH_INIT:
                begin
                    x_reg <= ini_x; y_reg <= ini_y; z_reg <= ini_z;
                    skip_reg <= ini_skip; step_reg <= '0;
                    state_reg <= S_PITCH;
                end
                S_PITCH:
                begin
                    if (!skip_reg)
                    begin
                        x_reg <= xn; y_reg <= yn; z_reg <= zn;
                    end
                    step_reg <= step_reg + 5'd1;
                    if (skip_reg || step_reg == 5'(CordicSteps - 1))
                    begin
                        o_pitch_reg <= 15'(out_ang(skip_reg ? z_reg : zn, Lim90));
                        neg_reg   <= gsum[16];
                        num_reg   <= 50'(gmag) * 50'(GyroScale) + 50'(rate_c);
                        den_reg   <= {rate_c, 1'b0};
                        rem_reg   <= '0;
                        dcnt_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    // Restoring division, one quotient bit per cycle.
                    if (rem_sh >= 15'(den_reg))
                    begin
                        rem_reg <= rem_sh - 15'(den_reg);
                        quo_reg <= {quo_reg[48:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[48:0], 1'b0};
                    end
                    num_reg  <= {num_reg[48:0], 1'b0};
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (dcnt_reg == 6'd49) state_reg <= S_HDG;
                end
                S_HDG:
                begin
                    if (neg_reg)
                    begin
                        hdg_reg <= (hdg_reg >= HdgW'(quo_reg)) ? hdg_reg - HdgW'(quo_reg)
                                   : hdg_reg + FullTurn - HdgW'(quo_reg);
                    end
                    else
                    begin
                        hdg_reg <= (hdg_up >= (HdgW+1)'(FullTurn))
                                   ? HdgW'(hdg_up - (HdgW+1)'(FullTurn))
                                   : HdgW'(hdg_up);
                    end
                    prev_reg  <= it_reg.gyro_z;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        o_roll_reg <= roll_reg;
                        o_hdg_reg  <= 16'(hdg_reg >> (HeadingFracBits - AngleFracBits));
                        o_it_reg   <= it_reg;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign roll        = o_roll_reg;
    assign pitch       = o_pitch_reg;
    assign heading     = o_hdg_reg;
    assign out_accel_x = o_it_reg.accel_x;
    assign out_accel_y = o_it_reg.accel_y;
    assign out_accel_z = o_it_reg.accel_z;
    assign out_gyro_x  = o_it_reg.gyro_x;
    assign out_gyro_y  = o_it_reg.gyro_y;
    assign out_gyro_z  = o_it_reg.gyro_z;
endmodule
`default_nettype wire

@@ rtl/tilt_and_heading_estimator.sv @@
`default_nettype none
// ============================================================================
// Tilt and heading estimator
// Roll and pitch from the accelerometer by CORDIC, heading by integrating
// the yaw rate.
// ============================================================================
// Input is a queue: an item transfers when push is high and full is low.
// Results are a queue: a result is on the ports while empty is low and
// transfers when pop is high. A reset item (kind = 1) clears the heading and
// the previous yaw rate and gives no result.
// A two-entry queue buffers items ahead of the engine. On its way from the
// input transfer to the result register a sample passes the queue, two
// multiplies, two 20-step CORDIC passes with a load step each on one shared
// iteration unit, 27 square-root steps, 50 divider steps, a heading update
// and the output load. A CORDIC pass whose operands lie on an axis ends at
// once without iterating. A reset item is handled in the idle state alone.
// The finished result sits in an output register; the engine may take the
// next sample only once that register is free, so it works on one sample at
// a time, and a stalled receiver fills the queue and then raises full.
// Reset zeroes the heading, empties queue and output; the rate register goes
// to 400 Hz. Write the rate register only while the block is idle.
// ============================================================================
module tilt_and_heading_estimator
    import the_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [12:0]        cfg_wdata,
    input  wire logic               push,
    output logic                    full,
    input  wire logic               kind,
    input  wire logic signed [15:0] accel_x,
    input  wire logic signed [15:0] accel_y,
    input  wire logic signed [15:0] accel_z,
    input  wire logic signed [15:0] gyro_x,
    input  wire logic signed [15:0] gyro_y,
    input  wire logic signed [15:0] gyro_z,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [15:0]      roll,
    output logic signed [14:0]      pitch,
    output logic [15:0]             heading,
    output logic signed [15:0]      out_accel_x,
    output logic signed [15:0]      out_accel_y,
    output logic signed [15:0]      out_accel_z,
    output logic signed [15:0]      out_gyro_x,
    output logic signed [15:0]      out_gyro_y,
    output logic signed [15:0]      out_gyro_z
);
    logic [12:0] rate_reg;
    item_t       din, qout;
    logic        q_empty, take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= 13'd400;
        end
        else if (cfg_we)
        begin
            rate_reg <= cfg_wdata;
        end
    end

    assign din = '{kind, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z};

    the_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .din(din), .full(full),
        .pop(take), .dout(qout), .empty(q_empty)
    );

    the_engine u_engine (
        .clk(clk), .rst_n(rst_n), .rate(rate_reg), .item(qout),
        .item_valid(!q_empty), .item_take(take), .empty(empty), .pop(pop),
        .roll(roll), .pitch(pitch), .heading(heading),
        .out_accel_x(out_accel_x), .out_accel_y(out_accel_y),
        .out_accel_z(out_accel_z), .out_gyro_x(out_gyro_x),
        .out_gyro_y(out_gyro_y), .out_gyro_z(out_gyro_z)
    );
endmodule
`default_nettype wire

@@ bench/tilt_and_heading_estimator_test.sv @@
// ============================================================================
// Tilt and heading estimator testbench
// Drives sample and heading-reset items through the input queue, predicts
// roll, pitch, heading and the pass-through counts with an integer CORDIC
// and trapezoidal yaw integration, and checks every result transfer in order.
// ============================================================================
module tilt_and_heading_estimator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import the_pkg::*;

    localparam longint CycleLimit = 4000000;
    localparam int SettleCycles = 400;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic [15:0]        heading;
        logic signed [15:0] ax, ay, az, gx, gy, gz;
    } attitude_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [12:0] cfg_wdata = '0;
    logic push = 1'b0;
    logic full;
    logic kind = 1'b0;
    logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
    logic signed [15:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
    logic empty;
    logic pop = 1'b0;
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic [15:0] heading;
    logic signed [15:0] out_accel_x, out_accel_y, out_accel_z;
    logic signed [15:0] out_gyro_x, out_gyro_y, out_gyro_z;

    attitude_t expected_attitudes[$];
    int errors = 0;
    longint cycle_count = 0;
    bit pop_enable = 1'b1;

    // Model state.
    longint unsigned rate_hz = 400;
    longint heading_acc = 0;
    longint prev_yaw = 0;

    tilt_and_heading_estimator u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .push(push), .full(full), .kind(kind),
        .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
        .gyro_x(gyro_x), .gyro_y(gyro_y), .gyro_z(gyro_z),
        .empty(empty), .pop(pop), .roll(roll), .pitch(pitch), .heading(heading),
        .out_accel_x(out_accel_x), .out_accel_y(out_accel_y),
        .out_accel_z(out_accel_z), .out_gyro_x(out_gyro_x),
        .out_gyro_y(out_gyro_y), .out_gyro_z(out_gyro_z)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic longint floor_shr(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -((-(v + 1)) >>> s) - 1;
    endfunction

    function automatic longint arctan_table(int i);
        case (i)
            0: return 2949120;   1: return 1740967;  2: return 919879;
            3: return 466945;    4: return 234379;   5: return 117304;
            6: return 58666;     7: return 29335;    8: return 14668;
            9: return 7334;      10: return 3667;    11: return 1833;
            12: return 917;      13: return 458;     14: return 229;
            15: return 115;      16: return 57;      17: return 29;
            18: return 14;       default: return 7;
        endcase
    endfunction

    // atan2 in 1/65536 degree by 20 vectoring steps.
    function automatic longint vector_angle(longint y, longint x);
        longint z;
        longint dx, dy;
        z = 0;
        if (y == 0)
            return (x >= 0) ? 0 : (longint'(180) << 16);
        if (x == 0)
            return (y > 0) ? (longint'(90) << 16) : -(longint'(90) << 16);
        if (x < 0)
        begin
            z = (y > 0) ? (longint'(180) << 16) : -(longint'(180) << 16);
            x = -x;
            y = -y;
        end
        x = x <<< 20;
        y = y <<< 20;
        for (int i = 0; i < 20; i++)
        begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y > 0)
            begin
                x += dx; y -= dy; z += arctan_table(i);
            end
            else
            begin
                x -= dx; y += dy; z -= arctan_table(i);
            end
        end
        return z;
    endfunction

    function automatic longint round_angle(longint z, longint lim_deg);
        longint r, lim;
        r = floor_shr(z + (longint'(1) << 8), 9);
        lim = lim_deg * 128;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = longint'(1) << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic void predict_attitude(logic k, logic signed [15:0] ax,
        logic signed [15:0] ay, logic signed [15:0] az, logic signed [15:0] gx,
        logic signed [15:0] gy, logic signed [15:0] gz);
        attitude_t a;
        longint unsigned r, rt;
        longint g, num, den, q, h, full_turn;
        if (k)
        begin
            heading_acc = 0;
            prev_yaw = 0;
            return;
        end
        a.roll = 16'(round_angle(vector_angle(ay, az), 180));
        r = int_sqrt(longint'(longint'(ay) * ay + longint'(az) * az) << 20);
        a.pitch = 15'(round_angle(vector_angle(-longint'(ax) * 1024, longint'(r)), 90));
        rt = rate_hz;
        if (rt < 4) rt = 4;
        if (rt > 6400) rt = 6400;
        g = ((longint'(305) << 24) + 5000) / 10000;
        num = (longint'(gz) + prev_yaw) * g;
        den = 2 * longint'(rt);
        q = (num >= 0) ? (num + den / 2) / den : -((-num + den / 2) / den);
        full_turn = longint'(360) << 24;
        h = heading_acc + q;
        if (h < 0) h += full_turn;
        else if (h >= full_turn) h -= full_turn;
        heading_acc = h;
        prev_yaw = gz;
        a.heading = 16'(heading_acc >> 17);
        a.ax = ax; a.ay = ay; a.az = az; a.gx = gx; a.gy = gy; a.gz = gz;
        expected_attitudes.push_back(a);
    endfunction

    task automatic report(string what, longint exp_v, longint act_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
        errors++;
    endtask

    // Result checker with random stalls on pop.
    initial
    begin
        attitude_t e;
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (expected_attitudes.size() == 0)
                begin
                    $display("%0t: unexpected result transfer, roll %0d", $time, roll);
                    errors++;
                end
                else
                begin
                    e = expected_attitudes.pop_front();
                    if (roll !== e.roll) report("roll", e.roll, roll);
                    if (pitch !== e.pitch) report("pitch", e.pitch, pitch);
                    if (heading !== e.heading) report("heading", e.heading, heading);
                    if (out_accel_x !== e.ax) report("out_accel_x", e.ax, out_accel_x);
                    if (out_accel_y !== e.ay) report("out_accel_y", e.ay, out_accel_y);
                    if (out_accel_z !== e.az) report("out_accel_z", e.az, out_accel_z);
                    if (out_gyro_x !== e.gx) report("out_gyro_x", e.gx, out_gyro_x);
                    if (out_gyro_y !== e.gy) report("out_gyro_y", e.gy, out_gyro_y);
                    if (out_gyro_z !== e.gz) report("out_gyro_z", e.gz, out_gyro_z);
                end
            end
            gap = $urandom_range(0, 19);
            if (!pop_enable || gap < 4)
                pop <= 1'b0;
            else if (gap == 4)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(20, 200)) @(posedge clk);
                pop <= 1'b1;
            end
            else
                pop <= 1'b1;
        end
    end

    task automatic idle_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return;
        push <= 1'b0;
        if (r < 18)
            repeat ($urandom_range(1, 3)) @(posedge clk);
        else
            repeat ($urandom_range(20, 250)) @(posedge clk);
    endtask

    task automatic send_item(logic k, logic signed [15:0] ax, logic signed [15:0] ay,
        logic signed [15:0] az, logic signed [15:0] gx, logic signed [15:0] gy,
        logic signed [15:0] gz);
        push <= 1'b1;
        kind <= k;
        accel_x <= ax; accel_y <= ay; accel_z <= az;
        gyro_x <= gx; gyro_y <= gy; gyro_z <= gz;
        do
            @(posedge clk);
        while (full);
        predict_attitude(k, ax, ay, az, gx, gy, gz);
        idle_gap();
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (expected_attitudes.size() != 0)
            @(posedge clk);
        // Reset items leave no result, so let the engine finish them too.
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_rate(logic [12:0] value);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        rate_hz = value;
    endtask

    function automatic logic signed [15:0] rand_count();
        int m;
        m = $urandom_range(0, 9);
        case (m)
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            3: return 16'($urandom_range(0, 7)) - 16'sd3;
            4: return 16'($urandom_range(0, 4000)) - 16'sd2000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_extremes();
        send_item(1'b0, 0, 0, 0, 0, 0, 0);
        send_item(1'b0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_item(1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_item(1'b0, 0, 0, 100, 1, -1, 32767);
        send_item(1'b0, 0, 0, -100, 2, -2, 32767);
        send_item(1'b0, 0, 100, 0, 3, 3, -32768);
        send_item(1'b0, 0, -100, 0, 4, 4, -32768);
        send_item(1'b0, 100, 0, 0, 5, 5, -32768);
        send_item(1'b0, -100, 0, 0, 6, 6, -32768);
        send_item(1'b0, 16'sh7fff, 16'sh8000, 16'sh7fff, -1, -1, -1);
        send_item(1'b0, -500, 1, -32768, 0, 0, 0);
        send_item(1'b0, 500, -1, -32768, 0, 0, 0);
        send_item(1'b1, 1234, 5678, -4321, 11, 22, 33);
        send_item(1'b0, 10, 20, 30, 40, 50, 60);
        send_item(1'b1, 0, 0, 0, 0, 0, 0);
        send_item(1'b1, 0, 0, 0, 0, 0, 0);
        send_item(1'b0, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
        send_item(1'b0, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_item(($urandom_range(0, 29) == 0), rand_count(), rand_count(),
                rand_count(), rand_count(), rand_count(), rand_count());
    endtask

    // Long runs of steady yaw so the heading wraps in both directions.
    task automatic test_heading_wrap(logic signed [15:0] yaw, int count);
        send_item(1'b1, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < count; i++)
            send_item(1'b0, rand_count(), rand_count(), rand_count(),
                rand_count(), rand_count(), yaw + 16'($urandom_range(0, 3)));
    endtask

    task automatic test_wait_for_empty();
        test_random(20);
        drain_results();
        test_random(20);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_random(300);
        test_wait_for_empty();
        write_rate(13'd4);
        test_heading_wrap(16'sh7ff0, 150);
        test_heading_wrap(-16'sh7ff0, 150);
        write_rate(13'd6400);
        test_random(250);
        write_rate(13'd0);
        test_random(150);
        write_rate(13'h1fff);
        test_random(150);
        write_rate(13'd3);
        test_random(100);
        write_rate(13'd6401);
        test_random(100);
        write_rate(13'($urandom_range(5, 6399)));
        test_random(300);
        drain_results();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
